// File: design/pf_pkg.sv
`default_nettype none

package pf_pkg;

	localparam int SQUARE_DIM = 5;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] pos_t;
	typedef letter_t [SQUARE_DIM-1:0] row_t;
	typedef row_t [SQUARE_DIM-1:0] square_t;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t LETTER_X = 5'd23;

	localparam square_t SQUARE_RESET = {
		25'd27025109,
		25'd21613104,
		25'd16201099,
		25'd10755269,
		25'd4294688
	};

	typedef struct packed {
		pos_t row;
		pos_t col;
	} loc_t;

	typedef struct packed {
		letter_t [3:0] letters;
		logic          four;
		logic          msg_end;
	} res_load_t;

	// first match in row-major order wins; no match gives row 0, column 0
	function automatic loc_t locate(square_t sq, letter_t l);
		loc_t r;
		r = '0;
		for (int i = SQUARE_DIM - 1; i >= 0; i--) begin
			for (int j = SQUARE_DIM - 1; j >= 0; j--) begin
				if (sq[i][j] == l) begin
					r.row = pos_t'(i);
					r.col = pos_t'(j);
				end
			end
		end
		return r;
	endfunction

	function automatic pos_t wrap_inc(pos_t p);
		return (p == pos_t'(SQUARE_DIM - 1)) ? '0 : p + pos_t'(1);
	endfunction

endpackage

`default_nettype wire

// File: design/pf_cipher.sv
`default_nettype none

module pf_cipher
	import pf_pkg::*;
(
	input  wire square_t sq,
	input  wire letter_t a,
	input  wire letter_t b,
	output letter_t      ca,
	output letter_t      cb
);

	loc_t la, lb;

	always_comb begin
		la = locate(sq, a);
		lb = locate(sq, b);
		priority if (la.row == lb.row) begin
			ca = sq[la.row][wrap_inc(la.col)];
			cb = sq[lb.row][wrap_inc(lb.col)];
		end else if (la.col == lb.col) begin
			ca = sq[wrap_inc(la.row)][la.col];
			cb = sq[wrap_inc(lb.row)][lb.col];
		end else begin
			ca = sq[la.row][lb.col];
			cb = sq[lb.row][la.col];
		end
	end

endmodule

`default_nettype wire

// File: design/pf_outbuf.sv
`default_nettype none

module pf_outbuf
	import pf_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            load,
	input  wire res_load_t load_data,
	input  wire            out_stall,
	output logic           out_valid,
	output letter_t        cipher_letter,
	output logic           run_last,
	output logic           message_done,
	output logic           free
);

	logic      valid_q;
	logic [1:0] idx_q;
	res_load_t buf_q;
	logic      last;

	assign last          = buf_q.four ? (idx_q == 2'd3) : (idx_q == 2'd1);
	assign free          = !valid_q || (!out_stall && last);
	assign out_valid     = valid_q;
	assign cipher_letter = buf_q.letters[idx_q];
	assign run_last      = last;
	assign message_done  = last && buf_q.msg_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (valid_q && !out_stall) begin
				if (last) begin
					valid_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// File: design/playfair_digraph_encryptor_top.sv
// Playfair digraph encryptor. Plaintext letters (A=0..Z=25, J folded into I)
// enter one item at a time; each item yields 0, 2 or 4 cipher letters on the
// result port, one per cycle while out_stall is low, with run_last on the
// last letter of an item and message_done on the final letter of a message.
// The result port sets the rate: in_stall holds the next item in the input
// stage until the output buffer is empty or is sending its last letter. Each
// letter is registered in the input stage, its cipher letters in the buffer.
// The 5x5 square is written through cfg_we/cfg_index/cfg_data, one row of five
// 5-bit codes per register, column 0 in the low bits; write it only while idle.
`default_nettype none

module playfair_digraph_encryptor_top
	import pf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire [4:0]   plain_letter,
	input  wire         message_end,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [4:0]  cipher_letter,
	output logic        run_last,
	output logic        message_done,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_index,
	input  wire [24:0]  cfg_data
);

	square_t   square_q;
	logic      pend_valid_q;
	letter_t   pend_letter_q;
	logic      valid_s1;
	letter_t   letter_s1;
	logic      end_s1;

	letter_t   letter;
	logic      eq;
	logic      advance;
	logic      buf_free;
	logic      has_res;
	letter_t   a0, b0;
	letter_t   c0a, c0b, c1a, c1b;
	res_load_t load_data;

	assign advance  = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	always_comb begin
		letter  = (letter_s1 == LETTER_J) ? LETTER_I : letter_s1;
		eq      = (pend_letter_q == letter);
		a0      = pend_valid_q ? pend_letter_q : letter;
		b0      = (pend_valid_q && !eq) ? letter : LETTER_X;
		has_res = pend_valid_q || end_s1;
		load_data.letters = {c1b, c1a, c0b, c0a};
		load_data.four    = pend_valid_q && eq && end_s1;
		load_data.msg_end = end_s1;
	end

	pf_cipher u_cipher0 (
		.sq (square_q),
		.a  (a0),
		.b  (b0),
		.ca (c0a),
		.cb (c0b)
	);

	pf_cipher u_cipher1 (
		.sq (square_q),
		.a  (letter),
		.b  (LETTER_X),
		.ca (c1a),
		.cb (c1b)
	);

	pf_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && has_res),
		.load_data     (load_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.cipher_letter (cipher_letter),
		.run_last      (run_last),
		.message_done  (message_done),
		.free          (buf_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q      <= SQUARE_RESET;
			pend_valid_q  <= 1'b0;
			pend_letter_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index < 3'(SQUARE_DIM))) begin
				square_q[cfg_index] <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				if (end_s1) begin
					pend_valid_q  <= 1'b0;
					pend_letter_q <= '0;
				end else if (!pend_valid_q || eq) begin
					pend_valid_q  <= 1'b1;
					pend_letter_q <= letter;
				end else begin
					pend_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			letter_s1 <= plain_letter;
			end_s1    <= message_end;
		end
	end

endmodule

`default_nettype wire

// File: bench/tb_playfair_digraph_encryptor_top.sv
module tb_playfair_digraph_encryptor_top
	import pf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [2:0] REG_SQUARE_ROW_0 = 3'd0;

	typedef struct packed {
		letter_t letter;
		logic    run_last;
		logic    message_done;
	} cipher_rec_t;

	// typed = 1: the cipher letters below are the expected output, else the predictor decides
	typedef struct packed {
		letter_t         letter;
		logic            msg_end;
		logic            typed;
		logic [2:0]      n_out;
		letter_t [0:3]   cipher;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  plain_letter = '0;
	logic        message_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  cipher_letter;
	logic        run_last;
	logic        message_done;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [24:0] cfg_data = '0;

	square_t     cipher_square;
	logic        pend_valid;
	letter_t     pend_letter;
	cipher_rec_t predicted [0:3];
	cipher_rec_t cipher_q [$];

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_off_left = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          msg_left = 0;
	letter_t     last_letter = '0;
	stim_row_t   directed_rows [23];

	playfair_digraph_encryptor_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.plain_letter (plain_letter),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cipher_letter(cipher_letter),
		.run_last     (run_last),
		.message_done (message_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	function automatic letter_t square_cell(int r, int c);
		return cipher_square[r][c];
	endfunction

	// first hit in row-major order; a letter not in the square sits at row 0, column 0
	function automatic void find_cell(letter_t l, output int r, output int c);
		bit hit;
		hit = 1'b0;
		r = 0;
		c = 0;
		for (int i = 0; i < SQUARE_DIM; i++) begin
			for (int j = 0; j < SQUARE_DIM; j++) begin
				if (!hit && square_cell(i, j) == l) begin
					hit = 1'b1;
					r = i;
					c = j;
				end
			end
		end
	endfunction

	function automatic int add_pair(letter_t a, letter_t b, int k);
		int ra, ca, rb, cb;
		letter_t ea, eb;
		find_cell(a, ra, ca);
		find_cell(b, rb, cb);
		if (ra == rb) begin
			ea = square_cell(ra, (ca + 1) % SQUARE_DIM);
			eb = square_cell(rb, (cb + 1) % SQUARE_DIM);
		end else if (ca == cb) begin
			ea = square_cell((ra + 1) % SQUARE_DIM, ca);
			eb = square_cell((rb + 1) % SQUARE_DIM, cb);
		end else begin
			ea = square_cell(ra, cb);
			eb = square_cell(rb, ca);
		end
		predicted[k] = '{ea, 1'b0, 1'b0};
		predicted[k + 1] = '{eb, 1'b0, 1'b0};
		return k + 2;
	endfunction

	function automatic int encipher_letter(letter_t letter_in, logic msg_end);
		letter_t l;
		int k;
		l = (letter_in == LETTER_J) ? LETTER_I : letter_in;
		k = 0;
		if (pend_valid) begin
			if (pend_letter == l) begin
				k = add_pair(pend_letter, LETTER_X, k);
			end else begin
				k = add_pair(pend_letter, l, k);
				pend_valid = 1'b0;
			end
		end else begin
			pend_valid = 1'b1;
			pend_letter = l;
		end
		if (msg_end) begin
			if (pend_valid)
				k = add_pair(pend_letter, LETTER_X, k);
			pend_valid = 1'b0;
			pend_letter = '0;
			predicted[k - 1].message_done = 1'b1;
		end
		if (k > 0)
			predicted[k - 1].run_last = 1'b1;
		return k;
	endfunction

	function automatic square_t shuffled_square();
		letter_t pool [25];
		letter_t t;
		square_t sq;
		int n, j;
		n = 0;
		for (int l = 0; l < 26; l++) begin
			if (letter_t'(l) != LETTER_J) begin
				pool[n] = letter_t'(l);
				n++;
			end
		end
		for (int i = 24; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int i = 0; i < 25; i++)
			sq[i / SQUARE_DIM][i % SQUARE_DIM] = pool[i];
		return sq;
	endfunction

	function automatic square_t raw_square();
		square_t sq;
		for (int r = 0; r < SQUARE_DIM; r++)
			sq[r] = row_t'($urandom);
		return sq;
	endfunction

	task automatic offer_letter(input letter_t l, input logic msg_end);
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		plain_letter <= l;
		message_end <= msg_end;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_letter(input letter_t l, input logic msg_end);
		int n;
		offer_letter(l, msg_end);
		n = encipher_letter(l, msg_end);
		for (int k = 0; k < n; k++)
			cipher_q.push_back(predicted[k]);
	endtask

	// random letters with doubled letters and J mixed in; a few codes outside the alphabet
	task automatic send_random(input int count);
		letter_t l;
		int pick;
		repeat (count) begin
			if (msg_left == 0)
				msg_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
					: $urandom_range(12, 1);
			pick = $urandom_range(99, 0);
			if (pick < 25)
				l = last_letter;
			else if (pick < 30)
				l = LETTER_J;
			else if (pick < 35)
				l = letter_t'($urandom_range(31, 26));
			else
				l = letter_t'($urandom_range(25, 0));
			last_letter = l;
			msg_left--;
			send_letter(l, msg_left == 0);
		end
	endtask

	task automatic settle(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_square(input square_t sq);
		settle(SETTLE_CYCLES);
		for (int r = 0; r < SQUARE_DIM; r++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= REG_SQUARE_ROW_0 + 3'(r);
			cfg_data <= sq[r];
			cipher_square[r] = sq[r];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic flag_result(input string what, input cipher_rec_t want, input cipher_rec_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected letter %0d run_last %b done %b, got letter %0d run_last %b done %b",
				what, want.letter, want.run_last, want.message_done,
				got.letter, got.run_last, got.message_done);
	endtask

	always @(posedge clk) begin : check_results
		cipher_rec_t got;
		cipher_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{cipher_letter, run_last, message_done};
			if (cipher_q.size() == 0) begin
				flag_result("unexpected item", '0, got);
			end else begin
				want = cipher_q.pop_front();
				if (got != want)
					flag_result("mismatch", want, got);
			end
		end
	end

	initial begin : stimulus
		int n;
		directed_rows = '{
			'{5'd0,      1'b0, 1'b1, 3'd0, '0},                              // A waits
			'{5'd1,      1'b0, 1'b1, 3'd2, {5'd1, 5'd2, 10'd0}},             // AB same row
			'{5'd25,     1'b1, 1'b1, 3'd2, {5'd21, 5'd24, 10'd0}},           // lone Z at end
			'{5'd4,      1'b0, 1'b1, 3'd0, '0},
			'{5'd4,      1'b0, 1'b1, 3'd2, {5'd2, 5'd25, 10'd0}},            // EE -> EX
			'{5'd4,      1'b1, 1'b1, 3'd4, {5'd2, 5'd25, 5'd2, 5'd25}},      // EE at end
			'{5'd0,      1'b0, 1'b1, 3'd0, '0},
			'{5'd5,      1'b0, 1'b1, 3'd2, {5'd5, 5'd11, 10'd0}},            // same column
			'{5'd16,     1'b0, 1'b1, 3'd0, '0},
			'{5'd21,     1'b0, 1'b1, 3'd2, {5'd21, 5'd0, 10'd0}},            // column wrap
			'{5'd3,      1'b0, 1'b1, 3'd0, '0},
			'{5'd4,      1'b0, 1'b1, 3'd2, {5'd4, 5'd0, 10'd0}},             // row wrap
			'{LETTER_I,  1'b0, 1'b1, 3'd0, '0},
			'{LETTER_J,  1'b0, 1'b1, 3'd2, {5'd7, 5'd24, 10'd0}},            // J folds to I
			'{LETTER_J,  1'b1, 1'b1, 3'd4, {5'd7, 5'd24, 5'd7, 5'd24}},
			'{LETTER_X,  1'b0, 1'b1, 3'd0, '0},
			'{LETTER_X,  1'b0, 1'b1, 3'd2, {5'd24, 5'd24, 10'd0}},           // XX
			'{5'd31,     1'b1, 1'b0, 3'd0, '0},                              // off-alphabet codes
			'{5'd26,     1'b0, 1'b0, 3'd0, '0},
			'{5'd30,     1'b0, 1'b0, 3'd0, '0},
			'{5'd0,      1'b1, 1'b1, 3'd2, {5'd2, 5'd21, 10'd0}},
			'{5'd25,     1'b0, 1'b0, 3'd0, '0},
			'{5'd16,     1'b1, 1'b0, 3'd0, '0}
		};
		cipher_square = SQUARE_RESET;
		pend_valid = 1'b0;
		pend_letter = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			offer_letter(directed_rows[i].letter, directed_rows[i].msg_end);
			n = encipher_letter(directed_rows[i].letter, directed_rows[i].msg_end);
			if (directed_rows[i].typed) begin
				for (int k = 0; k < directed_rows[i].n_out; k++)
					cipher_q.push_back('{directed_rows[i].cipher[k],
						k == directed_rows[i].n_out - 1,
						directed_rows[i].msg_end && k == directed_rows[i].n_out - 1});
			end else begin
				for (int k = 0; k < n; k++)
					cipher_q.push_back(predicted[k]);
			end
		end
		send_random(50);

		load_square(shuffled_square());
		idle_pct = 56;
		stall_pct = 0;
		send_random(45);

		load_square('0);
		idle_pct = 0;
		stall_pct = 56;
		send_random(45);

		load_square('1);
		idle_pct = 20;
		stall_pct = 20;
		send_random(45);

		// long receiver hold-off while items keep coming
		load_square(raw_square());
		idle_pct = 0;
		stall_pct = 20;
		hold_off_left = HOLD_OFF_CYCLES;
		send_random(45);

		load_square(shuffled_square());
		idle_pct = 56;
		stall_pct = 0;
		send_random(25);
		settle(0);
		idle_pct = 0;
		send_random(25);

		load_square(SQUARE_RESET);
		idle_pct = 20;
		stall_pct = 20;
		send_random(45);

		settle(20);
		if (mismatch_count == 0 && cipher_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
